// ===== src/slpm_pkg.sv =====
package slpm_pkg;

   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 72;
   localparam int RND_W  = ACC_W - 16;
   localparam int COS_W  = 18;

   // stencil constant term 205/72 in q16.16, placed in q32.32
   localparam logic signed [ACC_W-1:0] STENCIL_BIAS = ACC_W'(64'sd186596 <<< 16);
   localparam logic signed [ACC_W-1:0] HALF_LSB     = ACC_W'(32768);

   typedef enum logic [1:0] {
      OP_LOAD_MAT   = 2'd0,
      OP_LOAD_PHASE = 2'd1,
      OP_GRID       = 2'd2,
      OP_UNUSED     = 2'd3
   } op_type;

   typedef enum logic {
      CSR_GRID_SIZE   = 1'b0,
      CSR_INV_SPACING = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PH_RD,
      ST_PH_LAT,
      ST_COS_MUL,
      ST_COS_FIN,
      ST_W_MUL,
      ST_W_ACC,
      ST_S_RND,
      ST_S_MUL,
      ST_S_ACC,
      ST_C_FIN,
      ST_ROW,
      ST_MA,
      ST_MB,
      ST_CRE,
      ST_CIM,
      ST_CFIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic               clip;
   } sat_type;

   // quarter-wave cosine, q16.16, steps of 1024 angle units
   function automatic logic [16:0] cos_tab(input logic [4:0] i);
      logic [16:0] v;
      unique case (i)
         5'd0:    v = 17'd65536;
         5'd1:    v = 17'd65220;
         5'd2:    v = 17'd64277;
         5'd3:    v = 17'd62714;
         5'd4:    v = 17'd60547;
         5'd5:    v = 17'd57798;
         5'd6:    v = 17'd54491;
         5'd7:    v = 17'd50660;
         5'd8:    v = 17'd46341;
         5'd9:    v = 17'd41576;
         5'd10:   v = 17'd36410;
         5'd11:   v = 17'd30893;
         5'd12:   v = 17'd25080;
         5'd13:   v = 17'd19024;
         5'd14:   v = 17'd12785;
         5'd15:   v = 17'd6424;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   // signed stencil weight of harmonic h+1, q16.16
   function automatic logic signed [MUL_W-1:0] stencil_weight(input logic [1:0] h);
      logic signed [MUL_W-1:0] w;
      unique case (h)
         2'd0: w = -MUL_W'(209715);
         2'd1: w =  MUL_W'(26214);
         2'd2: w = -MUL_W'(3329);
         2'd3: w =  MUL_W'(234);
      endcase
      return w;
   endfunction

   // half-up rounding of a q32.32 sum to q16.16
   function automatic logic signed [RND_W-1:0] round16(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] t;
      t = v + HALF_LSB;
      return t[ACC_W-1:16];
   endfunction

   function automatic sat_type sat32(input logic signed [RND_W-1:0] v);
      sat_type s;
      if (v > RND_W'(64'sd2147483647)) begin
         s.val  = 32'sh7FFFFFFF;
         s.clip = 1'b1;
      end else if (v < -RND_W'(64'sd2147483648)) begin
         s.val  = 32'sh80000000;
         s.clip = 1'b1;
      end else begin
         s.val  = v[31:0];
         s.clip = 1'b0;
      end
      return s;
   endfunction

endpackage

// ===== src/slpm_ram.sv =====
module slpm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/shifted_laplacian_pencil_matvec.sv =====
// shifted laplacian pencil matrix-vector product, q16.16
// input channel (req_*): one item per handshake. op load-matrix writes one entry of the
//   real laplacian, op load-phase writes one k-point phase, op grid adds one complex
//   value to the current pencil. loads and grid items that do not close a pencil leave
//   the block idle and ready for the next item.
// an item that closes a pencil starts the compute: the shift is built from the two
//   stencil symbols, then each row runs through the one shared multiplier, which
//   handles one real product a cycle in the matrix-entry loop (two per matrix entry);
//   req_ready stays low meanwhile.
// result channel (rsp_*): n items per pencil, rsp_last on the final one. a result sits
//   in an output register; if the receiver stalls, the row loop waits at that register.
// configuration (csr_*): write only, while idle; grid_size clamps to [2, MAX_GRID].
// reset: synchronous; counters and pencil position clear, registers take grid size 32
//   and inverse spacing 1.0. matrix, phase and pencil memories are not cleared.
module shifted_laplacian_pencil_matvec #(
   parameter int MAX_GRID = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_op,
   input  logic [9:0]                  req_index,
   input  logic signed [31:0]          req_value_re,
   input  logic signed [31:0]          req_value_im,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [31:0]          rsp_out_re,
   output logic signed [31:0]          rsp_out_im,
   output logic                        rsp_saturated,
   output logic                        rsp_last,
   input  logic                        csr_write_en,
   input  slpm_pkg::csr_index_type     csr_index,
   input  logic [31:0]                 csr_wdata
);
   import slpm_pkg::*;

   localparam int LAP_DEPTH = MAX_GRID * MAX_GRID;
   localparam int LAP_AW    = $clog2(LAP_DEPTH);
   localparam int CW        = $clog2(MAX_GRID);
   localparam int NW        = $clog2(MAX_GRID + 1);
   localparam int CMP_W     = NW + 1;

   // configuration
   logic [5:0]  grid_size_ff;
   logic [31:0] inv_spacing_ff;
   logic [NW-1:0] n_eff;

   // sequencer and counters
   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] outer_ff, outer_in;
   logic [CW-1:0] middle_ff, middle_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] r_ff, r_in;
   logic [LAP_AW-1:0] row_base_ff, row_base_in;
   logic [1:0]  harm_ff, harm_in;
   logic        sel_ff, sel_in;

   // datapath
   logic [15:0] ph_ff, ph_in;
   logic [15:0] ang_ff, ang_in;
   logic signed [COS_W-1:0] cos_ff, cos_in;
   logic signed [23:0] s_ff, s_in;
   logic signed [31:0] c_ff, c_in;
   logic cclip_ff, cclip_in;
   logic signed [ACC_W-1:0] acc_re_ff, acc_re_in;
   logic signed [ACC_W-1:0] acc_im_ff, acc_im_in;
   logic signed [ACC_W-1:0] cacc_ff, cacc_in;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] prod_ext;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] out_re_ff, out_re_in, out_im_ff, out_im_in;
   logic sat_ff, sat_in, last_ff, last_in;

   // memories
   logic              lap_we, ph_we, buf_we;
   logic [LAP_AW-1:0] lap_waddr, lap_raddr;
   logic [CW-1:0]     ph_waddr, ph_raddr, buf_raddr;
   logic [31:0]       lap_rdata;
   logic [15:0]       ph_rdata;
   logic [63:0]       buf_rdata;

   logic accept, grid_done, k_last, r_last, out_free;
   logic [CMP_W-1:0] cnt_next, k_next, r_next, mid_next, out_next;
   logic [31:0] idx_wide;

   // cosine interpolation
   logic [14:0] rr;
   logic [4:0]  ci;
   logic [9:0]  cf;
   logic [16:0] cbase, cdiff, cmag;

   sat_type c_sat, re_sat, im_sat;

   // ------------------------------------------------------------------
   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff   <= 6'd32;
         inv_spacing_ff <= 32'd65536;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_GRID_SIZE:   grid_size_ff   <= csr_wdata[5:0];
            CSR_INV_SPACING: inv_spacing_ff <= csr_wdata;
         endcase
      end
   end

   always_comb begin
      if (grid_size_ff < 6'd2) begin
         n_eff = NW'(2);
      end else if (32'(grid_size_ff) > 32'(MAX_GRID)) begin
         n_eff = NW'(MAX_GRID);
      end else begin
         n_eff = NW'(grid_size_ff);
      end
   end

   // ------------------------------------------------------------------
   // status decode
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign idx_wide  = 32'(req_index);

   assign cnt_next = CMP_W'(count_ff) + CMP_W'(1);
   assign k_next   = CMP_W'(k_ff) + CMP_W'(1);
   assign r_next   = CMP_W'(r_ff) + CMP_W'(1);
   assign mid_next = CMP_W'(middle_ff) + CMP_W'(1);
   assign out_next = CMP_W'(outer_ff) + CMP_W'(1);

   assign grid_done = cnt_next >= CMP_W'(n_eff);
   assign k_last    = k_next   >= CMP_W'(n_eff);
   assign r_last    = r_next   >= CMP_W'(n_eff);

   // ------------------------------------------------------------------
   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (accept && req_op == OP_GRID && grid_done) state_in = ST_PH_RD;
         ST_PH_RD:   state_in = ST_PH_LAT;
         ST_PH_LAT:  state_in = ST_COS_MUL;
         ST_COS_MUL: state_in = ST_COS_FIN;
         ST_COS_FIN: state_in = ST_W_MUL;
         ST_W_MUL:   state_in = ST_W_ACC;
         ST_W_ACC:   state_in = (harm_ff == 2'd3) ? ST_S_RND : ST_COS_MUL;
         ST_S_RND:   state_in = ST_S_MUL;
         ST_S_MUL:   state_in = ST_S_ACC;
         ST_S_ACC:   state_in = sel_ff ? ST_C_FIN : ST_PH_RD;
         ST_C_FIN:   state_in = ST_ROW;
         ST_ROW:     state_in = ST_MA;
         ST_MA:      state_in = ST_MB;
         ST_MB:      state_in = k_last ? ST_CRE : ST_MA;
         ST_CRE:     state_in = ST_CIM;
         ST_CIM:     state_in = ST_CFIN;
         ST_CFIN:    state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) state_in = r_last ? ST_IDLE : ST_ROW;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // memory ports and multiplier operands
   always_comb begin
      lap_we    = accept && (req_op == OP_LOAD_MAT) && (idx_wide < 32'(LAP_DEPTH));
      lap_waddr = idx_wide[LAP_AW-1:0];
      ph_we     = accept && (req_op == OP_LOAD_PHASE) && (idx_wide < 32'(MAX_GRID));
      ph_waddr  = idx_wide[CW-1:0];
      buf_we    = accept && (req_op == OP_GRID);
      ph_raddr  = sel_ff ? middle_ff : outer_ff;

      // matrix-entry loop reads ahead one entry in the second half of each step
      buf_raddr = k_ff;
      lap_raddr = row_base_ff + LAP_AW'(k_ff);
      unique case (state_ff)
         ST_ROW: begin
            buf_raddr = '0;
            lap_raddr = row_base_ff;
         end
         ST_MB: begin
            buf_raddr = k_last ? r_ff : k_next[CW-1:0];
            lap_raddr = row_base_ff + LAP_AW'(k_next);
         end
         ST_CRE, ST_CIM: buf_raddr = r_ff;
         default: ;
      endcase

      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_COS_MUL: begin
            mul_a = MUL_W'(cdiff);
            mul_b = MUL_W'(cf);
         end
         ST_W_MUL: begin
            mul_a = stencil_weight(harm_ff);
            mul_b = MUL_W'(cos_ff);
         end
         ST_S_MUL: begin
            mul_a = MUL_W'(s_ff);
            mul_b = MUL_W'({1'b0, inv_spacing_ff});
         end
         ST_MA: begin
            mul_a = MUL_W'($signed(lap_rdata));
            mul_b = MUL_W'($signed(buf_rdata[63:32]));
         end
         ST_MB: begin
            mul_a = MUL_W'($signed(lap_rdata));
            mul_b = MUL_W'($signed(buf_rdata[31:0]));
         end
         ST_CRE: begin
            mul_a = MUL_W'(c_ff);
            mul_b = MUL_W'($signed(buf_rdata[63:32]));
         end
         ST_CIM: begin
            mul_a = MUL_W'(c_ff);
            mul_b = MUL_W'($signed(buf_rdata[31:0]));
         end
         default: ;
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = ACC_W'(prod_ff);

   // table cosine: fold the quadrant, interpolate between quarter-wave entries
   always_comb begin
      rr    = ang_ff[14] ? (15'd16384 - {1'b0, ang_ff[13:0]}) : {1'b0, ang_ff[13:0]};
      ci    = rr[14:10];
      cf    = rr[9:0];
      cbase = cos_tab(ci);
      cdiff = cbase - cos_tab(ci + 5'd1);
      cmag  = cbase - 17'(prod_ff[PROD_W-1:10]);
   end

   assign c_sat  = sat32(-round16(cacc_ff));
   assign re_sat = sat32(round16(acc_re_ff));
   assign im_sat = sat32(round16(acc_im_ff));

   // ------------------------------------------------------------------
   // datapath and counter updates
   always_comb begin
      count_in     = count_ff;
      outer_in     = outer_ff;
      middle_in    = middle_ff;
      k_in         = k_ff;
      r_in         = r_ff;
      row_base_in  = row_base_ff;
      harm_in      = harm_ff;
      sel_in       = sel_ff;
      ph_in        = ph_ff;
      ang_in       = ang_ff;
      cos_in       = cos_ff;
      s_in         = s_ff;
      c_in         = c_ff;
      cclip_in     = cclip_ff;
      acc_re_in    = acc_re_ff;
      acc_im_in    = acc_im_ff;
      cacc_in      = cacc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_re_in    = out_re_ff;
      out_im_in    = out_im_ff;
      sat_in       = sat_ff;
      last_in      = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == OP_GRID) begin
               if (grid_done) begin
                  count_in = '0;
                  sel_in   = 1'b0;
                  cacc_in  = '0;
               end else begin
                  count_in = cnt_next[CW-1:0];
               end
            end
         end
         ST_PH_LAT: begin
            ph_in     = ph_rdata;
            ang_in    = ph_rdata;
            harm_in   = 2'd0;
            acc_re_in = STENCIL_BIAS;
         end
         ST_COS_FIN: begin
            cos_in = (ang_ff[15] ^ ang_ff[14]) ? -COS_W'(cmag) : COS_W'(cmag);
         end
         ST_W_ACC: begin
            acc_re_in = acc_re_ff + prod_ext;
            harm_in   = harm_ff + 2'd1;
            ang_in    = ang_ff + ph_ff;
         end
         ST_S_RND: s_in = 24'(round16(acc_re_ff));
         ST_S_ACC: begin
            cacc_in = cacc_ff + prod_ext;
            sel_in  = 1'b1;
         end
         ST_C_FIN: begin
            c_in        = c_sat.val;
            cclip_in    = c_sat.clip;
            r_in        = '0;
            row_base_in = '0;
            acc_re_in   = '0;
            acc_im_in   = '0;
         end
         ST_ROW: k_in = '0;
         ST_MA: begin
            // product of the previous entry's imaginary part lands now
            if (k_ff != '0) acc_im_in = acc_im_ff + prod_ext;
         end
         ST_MB: begin
            acc_re_in = acc_re_ff + prod_ext;
            if (!k_last) k_in = k_next[CW-1:0];
         end
         ST_CRE: acc_im_in = acc_im_ff + prod_ext;
         ST_CIM: acc_re_in = acc_re_ff + prod_ext;
         ST_CFIN: acc_im_in = acc_im_ff + prod_ext;
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_re_in    = re_sat.val;
               out_im_in    = im_sat.val;
               sat_in       = cclip_ff | re_sat.clip | im_sat.clip;
               last_in      = r_last;
               acc_re_in    = '0;
               acc_im_in    = '0;
               if (r_last) begin
                  // step to the next pencil
                  if (mid_next >= CMP_W'(n_eff)) begin
                     middle_in = '0;
                     outer_in  = (out_next >= CMP_W'(n_eff)) ? '0 : out_next[CW-1:0];
                  end else begin
                     middle_in = mid_next[CW-1:0];
                  end
               end else begin
                  r_in        = r_next[CW-1:0];
                  row_base_in = row_base_ff + LAP_AW'(n_eff);
               end
            end
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         outer_ff     <= '0;
         middle_ff    <= '0;
         k_ff         <= '0;
         r_ff         <= '0;
         row_base_ff  <= '0;
         harm_ff      <= '0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         outer_ff     <= outer_in;
         middle_ff    <= middle_in;
         k_ff         <= k_in;
         r_ff         <= r_in;
         row_base_ff  <= row_base_in;
         harm_ff      <= harm_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ph_ff     <= ph_in;
      ang_ff    <= ang_in;
      cos_ff    <= cos_in;
      s_ff      <= s_in;
      c_ff      <= c_in;
      cclip_ff  <= cclip_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
      cacc_ff   <= cacc_in;
      prod_ff   <= prod_in;
      out_re_ff <= out_re_in;
      out_im_ff <= out_im_in;
      sat_ff    <= sat_in;
      last_ff   <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_re    = out_re_ff;
   assign rsp_out_im    = out_im_ff;
   assign rsp_saturated = sat_ff;
   assign rsp_last      = last_ff;

   // ------------------------------------------------------------------
   // memories
   slpm_ram #(.WIDTH(32), .DEPTH(LAP_DEPTH)) u_lap_ram (
      .clock   (clock),
      .wr_en   (lap_we),
      .wr_addr (lap_waddr),
      .wr_data (req_value_re),
      .rd_addr (lap_raddr),
      .rd_data (lap_rdata)
   );

   slpm_ram #(.WIDTH(16), .DEPTH(MAX_GRID)) u_phase_ram (
      .clock   (clock),
      .wr_en   (ph_we),
      .wr_addr (ph_waddr),
      .wr_data (req_value_re[15:0]),
      .rd_addr (ph_raddr),
      .rd_data (ph_rdata)
   );

   slpm_ram #(.WIDTH(64), .DEPTH(MAX_GRID)) u_pencil_ram (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (count_ff),
      .wr_data ({req_value_re, req_value_im}),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

`ifndef SYNTHESIS
   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MA) |-> (CMP_W'(k_ff) < CMP_W'(n_eff)))
      else $error("column counter beyond pencil length");

   a_r_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (CMP_W'(r_ff) < CMP_W'(n_eff)))
      else $error("row counter beyond pencil length");

   a_start_compute: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_GRID && grid_done) |=> (state_ff == ST_PH_RD))
      else $error("closing item did not start the compute");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free && r_last) |=> (rsp_valid && rsp_last))
      else $error("final row not flagged last");
`endif

endmodule

// ===== tb/sv/shifted_laplacian_pencil_matvec_tb.sv =====
module shifted_laplacian_pencil_matvec_tb;
   import slpm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_GRID      = 32;
   localparam int MAT_DEPTH     = MAX_GRID * MAX_GRID;
   localparam int TOTAL_ITEMS   = 170;
   localparam int PHASE_INIT    = 8;
   localparam int STALL_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;

   // quarter-wave cosine points, q16.16, every 1024 angle units
   localparam int COS_PTS [17] = '{
      65536, 65220, 64277, 62714, 60547, 57798, 54491, 50660, 46341,
      41576, 36410, 30893, 25080, 19024, 12785, 6424, 0
   };

   typedef struct {
      logic signed [31:0] re;
      logic signed [31:0] im;
      logic               sat;
      logic               last;
   } elem_result_type;

   typedef struct {
      op_type      op;
      logic [9:0]  idx;
      logic [31:0] re;
      logic [31:0] im;
      bit          pinned;
      logic [31:0] ere;
      logic [31:0] eim;
      bit          esat;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_op;
   logic [9:0]         req_index;
   logic signed [31:0] req_value_re;
   logic signed [31:0] req_value_im;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_out_re;
   logic signed [31:0] rsp_out_im;
   logic               rsp_saturated;
   logic               rsp_last;
   logic               csr_write_en;
   csr_index_type      csr_index;
   logic [31:0]        csr_wdata;

   shifted_laplacian_pencil_matvec #(.MAX_GRID(MAX_GRID)) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_index     (req_index),
      .req_value_re  (req_value_re),
      .req_value_im  (req_value_im),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_re    (rsp_out_re),
      .rsp_out_im    (rsp_out_im),
      .rsp_saturated (rsp_saturated),
      .rsp_last      (rsp_last),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // mirror of the block: registers, memories, pencil position
   logic [5:0]  size_reg = 6'd32;
   logic [31:0] inv_sq_reg = 32'd65536;
   int          lap_mem [MAT_DEPTH];
   logic [15:0] phase_mem [MAX_GRID];
   int          xre_mem [MAX_GRID];
   int          xim_mem [MAX_GRID];
   int unsigned elem_cnt = 0;
   int unsigned outer_k = 0;
   int unsigned middle_k = 0;

   // results typed into the directed table, keyed by pencil element
   bit              pin_on = 0;
   elem_result_type pin_val;
   bit              pinned_ok [MAX_GRID];
   elem_result_type pinned_res [MAX_GRID];

   elem_result_type pencil_results_q [$];
   int              errors = 0;
   int              idle_cycles = 0;
   int              items_sent = 0;
   bit              calm = 0;
   bit              hold_req = 0;
   bit              mat_written [MAT_DEPTH];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   function automatic int unsigned grid_n();
      if (size_reg < 2) return 2;
      if (size_reg > MAX_GRID) return MAX_GRID;
      return size_reg;
   endfunction

   // table cosine of a 16-bit angle, interpolated, quadrant folded
   function automatic longint cos_q(logic [15:0] a);
      int unsigned r, i, f;
      longint      v;
      r = a[13:0];
      if (a[14]) r = 16384 - r;
      i = r >> 10;
      f = r & 1023;
      if (i >= 16) v = 0;
      else v = COS_PTS[i] - ((int'(COS_PTS[i] - COS_PTS[i+1]) * f) >> 10);
      return (a[15] ^ a[14]) ? -v : v;
   endfunction

   // eighth-order stencil symbol of one k-point phase, q16.16
   function automatic longint stencil_q(logic [15:0] ph);
      logic [15:0] a2, a3, a4;
      longint      d;
      a2 = ph << 1;
      a3 = ph + a2;
      a4 = ph << 2;
      d = longint'(186596) <<< 16;
      d = d - 209715 * cos_q(ph) + 26214 * cos_q(a2) - 3329 * cos_q(a3)
          + 234 * cos_q(a4);
      return (d + 32768) >>> 16;
   endfunction

   function automatic logic [31:0] clip32(logic signed [95:0] v, inout bit clipped);
      if (v > 96'sd2147483647) begin
         clipped = 1;
         return 32'h7FFFFFFF;
      end
      if (v < -96'sd2147483648) begin
         clipped = 1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   // one accepted input item; a closing grid item queues the whole product
   task automatic absorb_item(logic [1:0] op, logic [9:0] idx, logic [31:0] re,
                              logic [31:0] im);
      int unsigned        n, r, k;
      longint             sx, sy;
      logic signed [95:0] c, acc_re, acc_im;
      bit                 cclip, clip;
      elem_result_type    res;
      n = grid_n();
      case (op)
         OP_LOAD_MAT: lap_mem[idx] = re;
         OP_LOAD_PHASE: if (idx < MAX_GRID) phase_mem[idx] = re[15:0];
         OP_GRID: begin
            xre_mem[elem_cnt] = re;
            xim_mem[elem_cnt] = im;
            pinned_ok[elem_cnt] = pin_on;
            pinned_res[elem_cnt] = pin_val;
            if (elem_cnt + 1 < n) begin
               elem_cnt++;
            end else begin
               sx = stencil_q(phase_mem[outer_k]) * longint'({32'd0, inv_sq_reg});
               sy = stencil_q(phase_mem[middle_k]) * longint'({32'd0, inv_sq_reg});
               c = -((96'(sx) + 96'(sy) + 32768) >>> 16);
               cclip = 0;
               c = $signed(clip32(c, cclip));
               for (r = 0; r < n; r++) begin
                  acc_re = 0;
                  acc_im = 0;
                  for (k = 0; k < n; k++) begin
                     acc_re += longint'(lap_mem[r*n+k]) * longint'(xre_mem[k]);
                     acc_im += longint'(lap_mem[r*n+k]) * longint'(xim_mem[k]);
                  end
                  acc_re += c * longint'(xre_mem[r]);
                  acc_im += c * longint'(xim_mem[r]);
                  clip = cclip;
                  res.re = clip32((acc_re + 32768) >>> 16, clip);
                  res.im = clip32((acc_im + 32768) >>> 16, clip);
                  res.sat = clip;
                  res.last = (r + 1 == n);
                  if (pinned_ok[r]) begin
                     res.re = pinned_res[r].re;
                     res.im = pinned_res[r].im;
                     res.sat = pinned_res[r].sat;
                  end
                  pencil_results_q.push_back(res);
                  pinned_ok[r] = 0;
               end
               elem_cnt = 0;
               if (middle_k + 1 >= n) begin
                  middle_k = 0;
                  outer_k = (outer_k + 1 >= n) ? 0 : outer_k + 1;
               end else begin
                  middle_k++;
               end
            end
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------
   // monitor and checker, sampled at the rising edge
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      elem_result_type want;
      if (!reset) begin
         if (csr_write_en || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (req_valid && req_ready) begin
            absorb_item(req_op, req_index, req_value_re, req_value_im);
         end
         if (rsp_valid && rsp_ready) begin
            if (pencil_results_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected item: re %h im %h sat %b last %b",
                           rsp_out_re, rsp_out_im, rsp_saturated, rsp_last);
            end else begin
               want = pencil_results_q.pop_front();
               if (rsp_out_re !== want.re || rsp_out_im !== want.im ||
                   rsp_saturated !== want.sat || rsp_last !== want.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected re %h im %h sat %b last %b, ",
                              want.re, want.im, want.sat, want.last,
                              "got re %h im %h sat %b last %b",
                              rsp_out_re, rsp_out_im, rsp_saturated, rsp_last);
               end
            end
         end
      end
   end

   // watchdog: too long with nothing moving on any port
   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // result side: random stalls, one long hold-off on request
   // ---------------------------------------------------------------

   initial begin
      bit hold_done;
      hold_done = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            // long hold-off so the output backs up and req_ready drops
            hold_done = 1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= 26);
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   // one item; leaves valid high on return, at a falling edge
   task automatic send_item(logic [1:0] op, logic [9:0] idx, logic [31:0] re,
                            logic [31:0] im);
      if (!calm && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_index    <= idx;
      req_value_re <= re;
      req_value_im <= im;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   // wait for every pending item plus the block's tail, then stay idle
   task automatic drain();
      req_valid <= 1'b0;
      while (pencil_results_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      if (idx == CSR_GRID_SIZE) size_reg = data[5:0];
      else inv_sq_reg = data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // mostly within +-2.0, sometimes the full range
   function automatic logic [31:0] rand_word();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return $urandom_range(0, 32'h3FFFF) - 32'h20000;
   endfunction

   stim_row_type directed_rows [18];

   initial begin
      int unsigned n, cnt, raw, phase_no, r;
      logic [31:0] inv;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_op       = OP_LOAD_MAT;
      req_index    = '0;
      req_value_re = '0;
      req_value_im = '0;
      csr_write_en = 1'b0;
      csr_index    = CSR_GRID_SIZE;
      csr_wdata    = '0;
      foreach (mat_written[i]) mat_written[i] = 0;
      foreach (pinned_ok[i]) pinned_ok[i] = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero shift, then identity, then overflow, then a nonzero shift (n = 2)
      directed_rows = '{
         '{OP_UNUSED,     10'd0,  32'h12345678, 32'h9ABCDEF0, 0, 0, 0, 0},
         '{OP_LOAD_PHASE, 10'd40, 32'h0000FFFF, 32'h0,        0, 0, 0, 0},
         '{OP_LOAD_MAT,   10'd0,  32'h0,        32'h0,        0, 0, 0, 0},
         '{OP_LOAD_MAT,   10'd1,  32'h0,        32'h0,        0, 0, 0, 0},
         '{OP_LOAD_MAT,   10'd2,  32'h0,        32'h0,        0, 0, 0, 0},
         '{OP_LOAD_MAT,   10'd3,  32'h0,        32'h0,        0, 0, 0, 0},
         '{OP_GRID, 10'd0, 32'h7FFFFFFF, 32'h80000000, 1, 32'h0, 32'h0, 0},
         '{OP_GRID, 10'd0, 32'h80000000, 32'h7FFFFFFF, 1, 32'h0, 32'h0, 0},
         '{OP_LOAD_MAT,   10'd0,  32'h00010000, 32'h0,        0, 0, 0, 0},
         '{OP_LOAD_MAT,   10'd3,  32'h00010000, 32'h0,        0, 0, 0, 0},
         '{OP_GRID, 10'd0, 32'h7FFFFFFF, 32'h80000000, 1, 32'h7FFFFFFF, 32'h80000000, 0},
         '{OP_GRID, 10'd0, 32'hFFFFFFFF, 32'h00000001, 1, 32'hFFFFFFFF, 32'h00000001, 0},
         '{OP_LOAD_MAT,   10'd1,  32'h7FFFFFFF, 32'h0,        0, 0, 0, 0},
         '{OP_GRID, 10'd1023, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 0},
         '{OP_GRID, 10'd0, 32'h80000000, 32'h80000000, 0, 0, 0, 0},
         '{OP_LOAD_PHASE, 10'd1,  32'hFFFF4000, 32'h0,        0, 0, 0, 0},
         '{OP_GRID, 10'd0, 32'h00010000, 32'h0,        0, 0, 0, 0},
         '{OP_GRID, 10'd0, 32'h0,        32'h00010000, 0, 0, 0, 0}
      };

      // every phase a pencil can reach gets written before any pencil reads it
      write_reg(CSR_GRID_SIZE, 32'd2);
      for (r = 0; r < PHASE_INIT; r++) send_item(OP_LOAD_PHASE, 10'(r), 32'h0, 32'h0);

      foreach (directed_rows[i]) begin
         pin_on = directed_rows[i].pinned;
         pin_val.re = directed_rows[i].ere;
         pin_val.im = directed_rows[i].eim;
         pin_val.sat = directed_rows[i].esat;
         pin_val.last = 0;
         if (directed_rows[i].op == OP_LOAD_MAT) mat_written[directed_rows[i].idx] = 1;
         send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].re,
                   directed_rows[i].im);
         pin_on = 0;
      end

      // random phases, each with its own size and spacing
      phase_no = 0;
      while (items_sent < TOTAL_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       raw = $urandom_range(0, 1);
            default: raw = $urandom_range(2, 6);
         endcase
         if (phase_no == 1) raw = 4;
         if (phase_no == 2) raw = 6;
         case ($urandom_range(0, 5))
            0:       inv = 32'h0;
            1:       inv = 32'hFFFFFFFF;
            2:       inv = $urandom;
            3:       inv = 32'd65536;
            default: inv = $urandom_range(0, 32'h40000);
         endcase
         drain();
         write_reg(CSR_GRID_SIZE, raw);
         write_reg(CSR_INV_SPACING, inv);
         n = grid_n();
         calm = (phase_no == 2);

         for (r = 0; r < n * n; r++) begin
            if (!mat_written[r] || $urandom_range(0, 7) == 0) begin
               mat_written[r] = 1;
               send_item(OP_LOAD_MAT, 10'(r), rand_word(), $urandom);
            end
         end
         repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 3))
               0:       send_item(OP_LOAD_PHASE, 10'($urandom_range(32, 1023)),
                                  $urandom, $urandom);
               1:       send_item(OP_UNUSED, 10'($urandom), $urandom, $urandom);
               default: send_item(OP_LOAD_PHASE, 10'($urandom_range(0, 31)),
                                  $urandom, $urandom);
            endcase
         end

         // whole pencils, sometimes one left open across the next size change
         cnt = n * $urandom_range(1, 2);
         if (n < MAX_GRID && $urandom_range(0, 3) == 0) cnt += $urandom_range(1, n - 1);
         if (phase_no == 1) begin
            cnt = 3 * n;
            hold_req = 1;
         end
         repeat (cnt) send_item(OP_GRID, 10'($urandom), rand_word(), rand_word());
         calm = 0;
         phase_no++;
      end

      drain();
      repeat (100) @(negedge clock);
      if (errors == 0 && pencil_results_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== shifted_laplacian_pencil_matvec.f =====
src/slpm_pkg.sv
src/slpm_ram.sv
src/shifted_laplacian_pencil_matvec.sv
tb/sv/shifted_laplacian_pencil_matvec_tb.sv
